// File: hdl/abed_pkg.sv
// Shared types and constants for the audio bang event detector.
package abed_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_SILENT_LEVEL    = 3'd0;
    localparam logic [2:0] REG_TRIGGER_LEVEL   = 3'd1;
    localparam logic [2:0] REG_WINDOW_LEVEL    = 3'd2;
    localparam logic [2:0] REG_EVENT_LEVEL     = 3'd3;
    localparam logic [2:0] REG_WINDOW_LENGTH   = 3'd4;
    localparam logic [2:0] REG_HOLDOFF_SAMPLES = 3'd5;

    // Input function codes and result kinds.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;
    localparam logic KIND_BANG   = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Mean reported by a window in which no sample counted.
    localparam logic [16:0] NO_COUNT_MEAN = 17'd42;

    // Reciprocal of ten scaled by 2^23; exact for 20-bit dividends.
    localparam logic [19:0] RECIP_TEN  = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Number of bangs kept in the history; the entry fields are sized for this depth.
    localparam int HISTORY_DEPTH = 32;

    typedef struct packed {
        logic        func;
        logic [9:0]  sample;
        logic [26:0] time_ms;
        logic [4:0]  entry_index;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [16:0] loudness;
        logic [26:0] event_time;
        logic [5:0]  entries;
        logic        entry_valid;
    } out_t;

    typedef struct packed {
        logic [9:0]  silent_level;
        logic [16:0] trigger_level;
        logic [16:0] window_level;
        logic [16:0] event_level;
        logic [7:0]  window_length;
        logic [15:0] holdoff_samples;
    } cfg_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        func;
        logic [16:0] loud;
        logic [26:0] time_ms;
        logic [4:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        logic [16:0] loud;
        logic [26:0] time_ms;
    } hist_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WINDOW,
        PH_HOLDOFF
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_FINISH,
        BK_READ,
        BK_EMIT
    } back_state_t;

endpackage

// File: hdl/abed_front.sv
// Front end: accepts words and computes the scaled loudness of each sample.
module abed_front
    import abed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         in_item,
    input  logic [9:0]  silent_level,
    output logic        enq,
    output cmd_t        enq_data,
    input  logic        q_full
);

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    in_t         item_reg;
    logic [19:0] sq_reg;
    logic [29:0] phi_reg;
    logic [29:0] plo_reg;
    logic [16:0] loud_reg;
    logic [9:0]  diff;
    logic [39:0] prod;

    // Distance of the sample from the silent level.
    always_comb
    begin
        if (item_reg.sample > silent_level)
            diff = item_reg.sample - silent_level;
        else
            diff = silent_level - item_reg.sample;
        prod = {phi_reg, 10'b0} + {10'b0, plo_reg};
    end

    // Sequencer: square, two partial products, combine, hand over.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (push)
            begin
                busy_next = 1'b1;
                step_next = 2'd0;
            end
        end
        else if (step_reg != 2'd3)
            step_next = step_reg + 2'd1;
        else if (!q_full)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (!busy_reg && push)
            item_reg <= in_item;
        sq_reg   <= diff * diff;
        phi_reg  <= sq_reg[19:10] * RECIP_TEN;
        plo_reg  <= sq_reg[9:0] * RECIP_TEN;
        loud_reg <= prod[RECIP_SHIFT +: 17];
    end

    assign full = busy_reg;
    assign enq  = busy_reg && (step_reg == 2'd3) && !q_full;
    assign enq_data = '{func: item_reg.func, loud: loud_reg, time_ms: item_reg.time_ms,
                        entry_index: item_reg.entry_index};

endmodule

// File: hdl/abed_queue.sv
// Short command queue between the front and the back.
module abed_queue
    import abed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic enq,
    input  cmd_t enq_data,
    output logic q_full,
    input  logic deq,
    output cmd_t deq_data,
    output logic q_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    cmd_t          slots_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign q_full   = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign deq_data = slots_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (enq && !deq)
                count_reg <= count_reg + 1'b1;
            else if (deq && !enq)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (enq)
            slots_reg[wr_ptr_reg] <= enq_data;
    end

endmodule

// File: hdl/abed_back.sv
// Back end: capture window, serial mean divider, bang history and result register.
module abed_back
    import abed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  cmd_t deq_data,
    output logic deq,
    output logic empty,
    input  logic pop,
    output out_t out_item
);

    localparam int PW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int IW0 = (PW > CW) ? PW : CW;
    localparam int IW  = (IW0 > 5) ? IW0 : 5;
    localparam int SW  = IW + 1;
    localparam logic [SW-1:0] DEPTH = SW'(HISTORY_DEPTH);

    back_state_t   state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [7:0]    wc_reg, wc_next;
    logic [24:0]   sum_reg, sum_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [26:0]   ttime_reg, ttime_next;
    logic [15:0]   hc_reg, hc_next;
    logic [PW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [24:0]   quo_reg, quo_next;
    logic [7:0]    rem_reg, rem_next;
    logic [4:0]    dstep_reg, dstep_next;
    logic [16:0]   mean_reg, mean_next;
    logic          rvalid_reg, rvalid_next;
    out_t          res_reg, res_next;
    out_t          out_reg;
    logic          out_valid_reg;
    logic          out_load;

    hist_t         hist_mem [HISTORY_DEPTH];
    hist_t         rd_data_reg;
    logic          rd_en, wr_en;
    logic [PW-1:0] rd_slot, wr_slot;
    hist_t         wr_data;

    logic [SW-1:0] rd_sum, wr_sum, old_inc;
    logic [7:0]    len;
    logic [8:0]    trial;
    logic          qbit;

    // Slot arithmetic for the circular history.
    always_comb
    begin
        rd_sum = SW'(oldest_reg) + SW'(deq_data.entry_index);
        if (rd_sum >= DEPTH)
            rd_sum = rd_sum - DEPTH;
        wr_sum = SW'(oldest_reg) + SW'(count_reg);
        if (wr_sum >= DEPTH)
            wr_sum = wr_sum - DEPTH;
        old_inc = SW'(oldest_reg) + SW'(1);
        if (old_inc >= DEPTH)
            old_inc = '0;
        len   = (cfg.window_length == 8'd0) ? 8'd1 : cfg.window_length;
        trial = {rem_reg, quo_reg[24]};
        qbit  = (trial >= {1'b0, cnt_reg});
    end

    assign out_load = (state_reg == BK_EMIT) && (!out_valid_reg || pop);

    // Sequencer and window state.
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        wc_next     = wc_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        ttime_next  = ttime_reg;
        hc_next     = hc_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dstep_next  = dstep_reg;
        mean_next   = mean_reg;
        rvalid_next = rvalid_reg;
        res_next    = res_reg;
        deq         = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_slot     = PW'(rd_sum);
        wr_slot     = oldest_reg;
        wr_data     = '{loud: mean_reg, time_ms: ttime_reg};

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    deq = 1'b1;
                    if (deq_data.func == FUNC_READ)
                    begin
                        rd_en       = 1'b1;
                        rvalid_next = (SW'(deq_data.entry_index) < SW'(count_reg));
                        state_next  = BK_READ;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_WINDOW:
                            begin
                                if (deq_data.loud > cfg.window_level)
                                begin
                                    sum_next = sum_reg + 25'(deq_data.loud);
                                    cnt_next = cnt_reg + 8'd1;
                                end
                                wc_next = wc_reg + 8'd1;
                                if (wc_next >= len)
                                begin
                                    hc_next    = cfg.holdoff_samples;
                                    phase_next = (cfg.holdoff_samples != 16'd0) ?
                                                 PH_HOLDOFF : PH_IDLE;
                                    if (cnt_next != 8'd0)
                                    begin
                                        quo_next   = sum_next;
                                        rem_next   = '0;
                                        dstep_next = '0;
                                        state_next = BK_DIV;
                                    end
                                    else
                                    begin
                                        mean_next  = NO_COUNT_MEAN;
                                        state_next = BK_FINISH;
                                    end
                                end
                            end
                            PH_HOLDOFF:
                            begin
                                if (hc_reg != 16'd0)
                                    hc_next = hc_reg - 16'd1;
                                if (hc_next == 16'd0)
                                    phase_next = PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                if (deq_data.loud > cfg.trigger_level)
                                begin
                                    ttime_next = deq_data.time_ms;
                                    wc_next    = '0;
                                    sum_next   = '0;
                                    cnt_next   = '0;
                                    phase_next = PH_WINDOW;
                                end
                            end
                        endcase
                    end
                end
            end
            BK_DIV:
            begin
                // One quotient bit per cycle, restoring division.
                rem_next   = qbit ? 8'(trial - {1'b0, cnt_reg}) : trial[7:0];
                quo_next   = {quo_reg[23:0], qbit};
                dstep_next = dstep_reg + 5'd1;
                if (dstep_reg == 5'd24)
                begin
                    mean_next  = quo_next[16:0];
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (mean_reg > cfg.event_level)
                begin
                    wr_en = 1'b1;
                    if (SW'(count_reg) < DEPTH)
                    begin
                        wr_slot    = PW'(wr_sum);
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        wr_slot     = oldest_reg;
                        oldest_next = PW'(old_inc);
                    end
                    res_next   = '{kind: KIND_BANG, loudness: mean_reg, event_time: ttime_reg,
                                   entries: 6'(count_next), entry_valid: 1'b1};
                    state_next = BK_EMIT;
                end
                else
                    state_next = BK_IDLE;
            end
            BK_READ:
            begin
                res_next   = '{kind: KIND_READ,
                               loudness: rvalid_reg ? rd_data_reg.loud : 17'd0,
                               event_time: rvalid_reg ? rd_data_reg.time_ms : 27'd0,
                               entries: 6'(count_reg), entry_valid: rvalid_reg};
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_load)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            phase_reg     <= PH_IDLE;
            wc_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ttime_reg     <= '0;
            hc_reg        <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            dstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            wc_reg     <= wc_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            ttime_reg  <= ttime_next;
            hc_reg     <= hc_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            dstep_reg  <= dstep_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        mean_reg   <= mean_next;
        rvalid_reg <= rvalid_next;
        res_reg    <= res_next;
        if (out_load)
            out_reg <= res_reg;
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_slot] <= wr_data;
        if (rd_en)
            rd_data_reg <= hist_mem[rd_slot];
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

// File: hdl/audio_bang_event_detector_top.sv
// Top level of the audio bang event detector.
//
//   channel   direction  handshake           word
//   input     in         push / full         in_item  (func, sample, time_ms, entry_index)
//   result    out        empty / pop         out_item (kind, loudness, event_time,
//                                                      entries, entry_valid)
//   config    in         cfg_write           cfg_index, cfg_data
//
// The front takes a new word only after handing the last to the queue (square, partial
// products and combine, then handover). A sample that closes a window with counted samples
// holds the back in the serial 25-bit divider; a history read uses the registered read port.
// Reset is asynchronous; the history needs no clearing pass, since entries are only
// read below the fill count. A stalled result stalls the back only when it has a
// further result to deliver; the queue between front and back absorbs the rest.
module audio_bang_event_detector_top
    import abed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_t         in_item,
    output logic        empty,
    input  logic        pop,
    output out_t        out_item,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cfg_t cfg_reg;
    logic enq, q_full, deq, q_empty;
    cmd_t enq_data, deq_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silent_level    <= 10'd540;
            cfg_reg.trigger_level   <= 17'd420;
            cfg_reg.window_level    <= 17'd252;
            cfg_reg.event_level     <= 17'd1008;
            cfg_reg.window_length   <= 8'd84;
            cfg_reg.holdoff_samples <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SILENT_LEVEL:    cfg_reg.silent_level    <= cfg_data[9:0];
                REG_TRIGGER_LEVEL:   cfg_reg.trigger_level   <= cfg_data;
                REG_WINDOW_LEVEL:    cfg_reg.window_level    <= cfg_data;
                REG_EVENT_LEVEL:     cfg_reg.event_level     <= cfg_data;
                REG_WINDOW_LENGTH:   cfg_reg.window_length   <= cfg_data[7:0];
                REG_HOLDOFF_SAMPLES: cfg_reg.holdoff_samples <= cfg_data[15:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    abed_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .silent_level (cfg_reg.silent_level),
        .enq          (enq),
        .enq_data     (enq_data),
        .q_full       (q_full)
    );

    abed_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (enq_data),
        .q_full   (q_full),
        .deq      (deq),
        .deq_data (deq_data),
        .q_empty  (q_empty)
    );

    abed_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .deq_data (deq_data),
        .deq      (deq),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// File: sim/bang_checker.sv
// Checker for the bang event detector: predicts each result word and compares it.
module bang_checker
    import abed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_t         in_item,
    input  logic        empty,
    input  logic        pop,
    input  out_t        out_item,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int DEPTH = HISTORY_DEPTH;

    cfg_t        cfg;
    phase_t      phase;
    logic [7:0]  win_cnt;
    logic [24:0] loud_sum;
    logic [7:0]  loud_cnt;
    logic [26:0] trig_time;
    logic [15:0] hold_cnt;
    logic [16:0] hist_loud [DEPTH];
    logic [26:0] hist_time [DEPTH];
    logic [4:0]  oldest;
    logic [5:0]  count;
    out_t        expected_words [$];

    assign pending = expected_words.size();

    // Loudness of one raw sample against the silent level.
    function automatic logic [16:0] loudness_of(logic [9:0] s);
        int d;
        d = (s > cfg.silent_level) ? s - cfg.silent_level : cfg.silent_level - s;
        return 17'((d * d) / 10);
    endfunction

    // Advance the predicted state by one accepted word.
    task automatic predict_word(in_t w);
        out_t        r;
        logic [16:0] ld;
        logic [16:0] mean;
        int          len;
        int          slot;
        if (w.func == FUNC_READ) begin
            r = '0;
            r.kind = KIND_READ;
            r.entries = count;
            if (w.entry_index < count) begin
                slot = (oldest + w.entry_index) % DEPTH;
                r.loudness = hist_loud[slot];
                r.event_time = hist_time[slot];
                r.entry_valid = 1'b1;
            end
            expected_words.push_back(r);
            return;
        end
        ld = loudness_of(w.sample);
        if (phase == PH_WINDOW) begin
            len = (cfg.window_length == 0) ? 1 : cfg.window_length;
            if (ld > cfg.window_level) begin
                loud_sum = loud_sum + 25'(ld);
                loud_cnt = loud_cnt + 8'd1;
            end
            win_cnt = win_cnt + 8'd1;
            if (win_cnt < len)
                return;
            mean = (loud_cnt != 0) ? 17'(loud_sum / loud_cnt) : NO_COUNT_MEAN;
            hold_cnt = cfg.holdoff_samples;
            phase = (hold_cnt != 0) ? PH_HOLDOFF : PH_IDLE;
            if (mean > cfg.event_level) begin
                if (count < DEPTH) begin
                    slot = (oldest + count) % DEPTH;
                    count = count + 6'd1;
                end else begin
                    slot = oldest;
                    oldest = oldest + 5'd1;
                end
                hist_loud[slot] = mean;
                hist_time[slot] = trig_time;
                r.kind = KIND_BANG;
                r.loudness = mean;
                r.event_time = trig_time;
                r.entries = count;
                r.entry_valid = 1'b1;
                expected_words.push_back(r);
            end
        end else if (phase == PH_HOLDOFF) begin
            if (hold_cnt > 0)
                hold_cnt = hold_cnt - 16'd1;
            if (hold_cnt == 0)
                phase = PH_IDLE;
        end else begin
            phase = PH_IDLE;
            if (ld > cfg.trigger_level) begin
                trig_time = w.time_ms;
                win_cnt = '0;
                loud_sum = '0;
                loud_cnt = '0;
                phase = PH_WINDOW;
            end
        end
    endtask

    // Watch all three channels at each edge.
    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n) begin
            cfg = '{10'd540, 17'd420, 17'd252, 17'd1008, 8'd84, 16'd0};
            phase = PH_IDLE;
            win_cnt = '0;
            loud_sum = '0;
            loud_cnt = '0;
            trig_time = '0;
            hold_cnt = '0;
            oldest = '0;
            count = '0;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_SILENT_LEVEL:    cfg.silent_level = cfg_data[9:0];
                    REG_TRIGGER_LEVEL:   cfg.trigger_level = cfg_data;
                    REG_WINDOW_LEVEL:    cfg.window_level = cfg_data;
                    REG_EVENT_LEVEL:     cfg.event_level = cfg_data;
                    REG_WINDOW_LENGTH:   cfg.window_length = cfg_data[7:0];
                    REG_HOLDOFF_SAMPLES: cfg.holdoff_samples = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %p", out_item);
                    fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    if (out_item.kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, out_item.kind);
                        fail_count++;
                    end
                    if (out_item.loudness !== e.loudness) begin
                        $error("loudness: expected %0d, got %0d",
                               e.loudness, out_item.loudness);
                        fail_count++;
                    end
                    if (out_item.event_time !== e.event_time) begin
                        $error("event_time: expected %0d, got %0d",
                               e.event_time, out_item.event_time);
                        fail_count++;
                    end
                    if (out_item.entries !== e.entries) begin
                        $error("entries: expected %0d, got %0d",
                               e.entries, out_item.entries);
                        fail_count++;
                    end
                    if (out_item.entry_valid !== e.entry_valid) begin
                        $error("entry_valid: expected %0d, got %0d",
                               e.entry_valid, out_item.entry_valid);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predict_word(in_item);
        end
    end

endmodule

// File: sim/testbench.sv
// Stimulus and verdict for the bang event detector, with the checker beside it.
module testbench;
    import abed_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_t         in_item;
    logic        empty;
    logic        pop;
    out_t        out_item;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic [16:0] silent_now;

    // Count of accepted input words, for pacing the random phases.
    int accepted_words = 0;

    audio_bang_event_detector_top u_top (.*);

    bang_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (push && !full)
            accepted_words <= accepted_words + 1;
    end

    function automatic int u_checker_count();
        return accepted_words;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // The result side pops at random.
    initial
    begin
        int g;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            g = gap_len();
            pop <= (g == 0);
            repeat (g == 0 ? 1 : g) @(posedge clk);
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog on cycles without any accepted word, popped result or configuration write.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Push stays high after an accepted word; the next send or a drain changes it.
    task automatic send_word(in_t w);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_sample(logic [9:0] s);
        in_t w;
        w.func = FUNC_SAMPLE;
        w.sample = s;
        w.time_ms = 27'($urandom_range(0, 86399999));
        w.entry_index = 5'($urandom);
        send_word(w);
    endtask

    task automatic send_read(logic [4:0] idx);
        in_t w;
        w.func = FUNC_READ;
        w.sample = 10'($urandom);
        w.time_ms = 27'($urandom);
        w.entry_index = idx;
        send_word(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until the block has gone quiet, then allow for divider latency.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_all(logic [9:0] sl, logic [16:0] tl, logic [16:0] wl,
                           logic [16:0] el, logic [7:0] wn, logic [15:0] ho);
        drain();
        write_reg(REG_SILENT_LEVEL, 17'(sl));
        write_reg(REG_TRIGGER_LEVEL, tl);
        write_reg(REG_WINDOW_LEVEL, wl);
        write_reg(REG_EVENT_LEVEL, el);
        write_reg(REG_WINDOW_LENGTH, 17'(wn));
        write_reg(REG_HOLDOFF_SAMPLES, 17'(ho));
        silent_now = 17'(sl);
    endtask

    // One burst: an extreme trigger sample, then window and holdoff samples of mixed values.
    task automatic burst(int len, int hold);
        int k;
        send_sample($urandom_range(0, 1) ? 10'd1023 : 10'd0);
        for (k = 0; k < len + hold + $urandom_range(0, 3); k++) begin
            if ($urandom_range(0, 9) < 6)
                send_sample(10'($urandom));
            else
                send_sample(10'(silent_now[9:0] + $urandom_range(0, 6) - 3));
        end
        if ($urandom_range(0, 2) == 0)
            send_read(5'($urandom));
    endtask

    initial
    begin
        int i;
        int len;
        int hold;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SILENT_LEVEL;
        cfg_data = '0;
        silent_now = 17'd540;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of an empty history, extremes, reset settings.
        send_read(5'd0);
        send_read(5'd31);
        send_sample(10'd1023);
        for (i = 0; i < 84; i++)
            send_sample(i[0] ? 10'd1023 : 10'd0);
        send_read(5'd0);
        send_read(5'd1);
        // Window of length zero, nothing counted, mean 42 above event level.
        set_all(10'd0, 17'd0, 17'h1FFFF, 17'd41, 8'd0, 16'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_read(5'd0);
        // Holdoff of several samples, extreme levels.
        set_all(10'd1023, 17'd104651, 17'd0, 17'd0, 8'd1, 16'd3);
        send_sample(10'd0);
        send_sample(10'd0);
        for (i = 0; i < 4; i++)
            send_sample(10'd0);
        send_read(5'd0);
        send_read(5'd2);

        // Random phases with short windows, some extremes in between.
        for (i = 0; i < 12; i++) begin
            len = (i == 5) ? 255 : $urandom_range(0, 8);
            hold = (i == 7) ? 65535 : $urandom_range(0, 4);
            set_all(10'($urandom), 17'($urandom_range(0, 30000)),
                    17'($urandom_range(0, 30000)), 17'($urandom_range(0, 20000)),
                    8'(len), (hold > 10) ? 16'd2 : 16'(hold));
            if (hold > 10) begin
                drain();
                write_reg(REG_HOLDOFF_SAMPLES, 17'h0FFFF);
                hold = 3;
            end
            if (i == 3)
                write_reg(REG_EVENT_LEVEL, 17'h1FFFF);
            while (u_checker_count() < 95 * (i + 1)) begin
                if ($urandom_range(0, 9) == 0)
                    send_read(5'($urandom));
                else if ($urandom_range(0, 9) == 0)
                    send_sample(10'($urandom));
                else
                    burst((len == 0) ? 1 : len, (hold > 10) ? 0 : hold);
            end
        end

        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
